// ===== rtl/kwt_pkg.sv =====
`default_nettype none

package kwt_pkg;

    localparam int POSITION_WIDTH = 16;
    localparam int KEYWORD_COUNT  = 8;
    localparam int KW_USED        = (KEYWORD_COUNT < 8) ? KEYWORD_COUNT : 8;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W     = FIFO_PTR_W + 1;

    localparam logic [3:0] KIND_END     = 4'd0;
    localparam logic [3:0] KIND_COMMA   = 4'd1;
    localparam logic [3:0] KIND_COLON   = 4'd2;
    localparam logic [3:0] KIND_SEMI    = 4'd3;
    localparam logic [3:0] KIND_LBRACE  = 4'd4;
    localparam logic [3:0] KIND_RBRACE  = 4'd5;
    localparam logic [3:0] KIND_KEYWORD = 4'd6;
    localparam logic [3:0] KIND_NAME    = 4'd7;
    localparam logic [3:0] KIND_STRING  = 4'd8;

    localparam logic [3:0] NOT_KEYWORD = 4'd8;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNDEFINED = 2'd1;
    localparam logic [1:0] ERR_NEWLINE   = 2'd2;
    localparam logic [1:0] ERR_EOF_STR   = 2'd3;

    // keyword text, right aligned, first character in the highest used byte
    localparam logic [63:0] KW_TEXT [8] = '{
        64'("static"), 64'("scene"), 64'("shaders"), 64'("meshes"),
        64'("cbuffers"), 64'("textures"), 64'("name"), 64'("names")
    };
    localparam logic [3:0] KW_LEN [8] = '{
        4'd6, 4'd5, 4'd7, 4'd6, 4'd8, 4'd8, 4'd4, 4'd5
    };

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_IDENT  = 3'd1,
        MODE_STRING = 3'd2,
        MODE_SLASH  = 3'd3,
        MODE_LINE   = 3'd4,
        MODE_BLOCK  = 3'd5,
        MODE_BSTAR  = 3'd6
    } scan_mode_t;

    typedef logic [POSITION_WIDTH-1:0] pos_t;

    typedef struct packed {
        logic       last;
        logic [1:0] err;
        logic [15:0] len;
        logic [15:0] col;
        logic [15:0] line;
        logic [3:0] kw_id;
        logic [3:0] kind;
    } result_t;

    typedef struct packed {
        logic [1:0] cnt;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic pos_t sat_inc(input pos_t v);
        return (v != '1) ? pos_t'(v + 1'b1) : v;
    endfunction

    function automatic logic [15:0] out16(input pos_t v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || (c == 8'h5F);
    endfunction

    function automatic logic [7:0] kw_char(input int k, input logic [2:0] p);
        int idx;
        idx = int'(KW_LEN[k]) - 1 - int'(p);
        if (idx < 0)
        begin
            return 8'h00;
        end
        return KW_TEXT[k][idx*8 +: 8];
    endfunction

    // narrow the candidate mask by byte c at token position pos
    function automatic logic [7:0] kw_match(input logic [7:0] cand, input pos_t pos,
                                            input logic [7:0] c);
        logic [7:0] m;
        logic       in_range;
        m = cand;
        for (int k = 0; k < KW_USED; k++)
        begin
            in_range = (pos < pos_t'(KW_LEN[k]));
            if (!(cand[k] && in_range && (kw_char(k, pos[2:0]) == c)))
            begin
                m[k] = 1'b0;
            end
        end
        return m;
    endfunction

    function automatic logic [3:0] kw_lookup(input logic [7:0] cand, input pos_t count);
        logic [3:0] id;
        id = NOT_KEYWORD;
        for (int k = KW_USED - 1; k >= 0; k--)
        begin
            if (cand[k] && (count == pos_t'(KW_LEN[k])))
            begin
                id = 4'(k);
            end
        end
        return id;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/keyword_tokenizer_unit.sv =====
// channel | dir | signals                                       | payload
// s_axis  | in  | tvalid, tready, tdata[7:0]                    | text_byte
// m_axis  | out | tvalid, tready, tdata[55:0], tuser[3:0], tlast | token fields, last_of_run
//
// a byte is taken into an input register, scanned combinationally and its results
// written to a four-entry result queue; one byte per cycle while the queue has room
// a byte that closes an identifier yields up to two results, the identifier and its own token
// the input register moves on only when the queue has two free entries
// rst_n clears the scanner to line 1, column 1 and empties the queue
`default_nettype none

module keyword_tokenizer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // [3:0] kw_index, [19:4] line_number,
                                             // [35:20] column_number, [51:36] token_length,
                                             // [53:52] error_code
    output logic [3:0]       m_axis_tuser,   // [3:0] tok_class
    output logic             m_axis_tlast    // last_of_run
);

    logic             byte_valid_reg, byte_valid_next;
    logic [7:0]       byte_reg;
    logic             step, room, in_accept;
    kwt_pkg::push_t   push;
    kwt_pkg::result_t head;

    assign step          = byte_valid_reg && room;
    assign s_axis_tready = !byte_valid_reg || step;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        byte_valid_next = in_accept || (byte_valid_reg && !step);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= s_axis_tdata;
        end
    end

    kwt_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .text_byte (byte_reg),
        .push      (push)
    );

    kwt_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop_ready  (m_axis_tready),
        .head       (head),
        .head_valid (m_axis_tvalid),
        .room       (room)
    );

    assign m_axis_tdata = {2'b0, head.err, head.len, head.col, head.line, head.kw_id};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

`ifndef NO_ASSERTIONS
    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid_reg && !room |-> !s_axis_tready)
        else $error("input taken while the held byte cannot be scanned");
`endif

endmodule

`default_nettype wire

// ===== rtl/kwt_scan.sv =====
`default_nettype none

module kwt_scan (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [7:0]    text_byte,
    output kwt_pkg::push_t     push
);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    kwt_pkg::scan_mode_t mode_reg, mode_next, mode_eff;
    kwt_pkg::pos_t       line_reg, line_next;
    kwt_pkg::pos_t       col_reg, col_next;
    kwt_pkg::pos_t       start_reg, start_next;
    kwt_pkg::pos_t       count_reg, count_next;
    logic [7:0]          cand_reg, cand_next;

    kwt_pkg::result_t res_a, res_b;
    logic             a_vld, b_vld;
    logic             handled, adv, clr;
    logic [3:0]       id;

    function automatic kwt_pkg::result_t make_res(input logic [3:0] kind,
                                                  input logic [3:0] kw_id,
                                                  input kwt_pkg::pos_t line,
                                                  input kwt_pkg::pos_t col,
                                                  input kwt_pkg::pos_t len,
                                                  input logic [1:0] err);
        kwt_pkg::result_t r;
        r.last  = 1'b0;
        r.err   = err;
        r.len   = kwt_pkg::out16(len);
        r.col   = kwt_pkg::out16(col);
        r.line  = kwt_pkg::out16(line);
        r.kw_id = kw_id;
        r.kind  = kind;
        return r;
    endfunction

    always_comb
    begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        start_next = start_reg;
        count_next = count_reg;
        cand_next  = cand_reg;
        mode_eff   = mode_reg;
        res_a      = '0;
        res_b      = '0;
        a_vld      = 1'b0;
        b_vld      = 1'b0;
        handled    = 1'b0;
        adv        = 1'b0;
        clr        = 1'b0;
        id         = kwt_pkg::kw_lookup(cand_reg, count_reg);

        if (mode_reg == kwt_pkg::MODE_IDENT)
        begin
            if (kwt_pkg::is_ident(text_byte))
            begin
                cand_next  = kwt_pkg::kw_match(cand_reg, count_reg, text_byte);
                count_next = kwt_pkg::sat_inc(count_reg);
                handled    = 1'b1;
                adv        = 1'b1;
            end
            else
            begin
                a_vld     = 1'b1;
                res_a     = make_res((id == kwt_pkg::NOT_KEYWORD) ? kwt_pkg::KIND_NAME
                                                                  : kwt_pkg::KIND_KEYWORD,
                                     id, line_reg, start_reg, count_reg, kwt_pkg::ERR_NONE);
                mode_eff  = kwt_pkg::MODE_IDLE;
                mode_next = kwt_pkg::MODE_IDLE;
            end
        end

        if (!handled)
        begin
            case (mode_eff)
                kwt_pkg::MODE_STRING:
                begin
                    if (text_byte == CH_NUL)
                    begin
                        b_vld = 1'b1;
                        res_b = make_res(kwt_pkg::KIND_END, kwt_pkg::NOT_KEYWORD, line_reg,
                                         col_reg - 1'b1, '0, kwt_pkg::ERR_EOF_STR);
                        clr   = 1'b1;
                    end
                    else if (text_byte == CH_LF)
                    begin
                        b_vld = 1'b1;
                        res_b = make_res(kwt_pkg::KIND_END, kwt_pkg::NOT_KEYWORD, line_reg,
                                         col_reg - 1'b1, '0, kwt_pkg::ERR_NEWLINE);
                        clr   = 1'b1;
                    end
                    else
                    begin
                        count_next = kwt_pkg::sat_inc(count_reg);
                        if (text_byte == CH_QUOTE)
                        begin
                            b_vld     = 1'b1;
                            res_b     = make_res(kwt_pkg::KIND_STRING, kwt_pkg::NOT_KEYWORD,
                                                 line_reg, start_reg,
                                                 kwt_pkg::sat_inc(count_reg),
                                                 kwt_pkg::ERR_NONE);
                            mode_next = kwt_pkg::MODE_IDLE;
                        end
                        adv = 1'b1;
                    end
                end
                kwt_pkg::MODE_SLASH:
                begin
                    if (text_byte == CH_SLASH)
                    begin
                        mode_next = kwt_pkg::MODE_LINE;
                        adv       = 1'b1;
                    end
                    else if (text_byte == CH_STAR)
                    begin
                        mode_next = kwt_pkg::MODE_BLOCK;
                        adv       = 1'b1;
                    end
                    else
                    begin
                        b_vld = 1'b1;
                        res_b = make_res(kwt_pkg::KIND_END, kwt_pkg::NOT_KEYWORD, line_reg,
                                         start_reg - 1'b1, '0, kwt_pkg::ERR_UNDEFINED);
                        clr   = 1'b1;
                    end
                end
                kwt_pkg::MODE_LINE:
                begin
                    if (text_byte == CH_NUL)
                    begin
                        b_vld = 1'b1;
                        res_b = make_res(kwt_pkg::KIND_END, kwt_pkg::NOT_KEYWORD, line_reg,
                                         col_reg, '0, kwt_pkg::ERR_NONE);
                        clr   = 1'b1;
                    end
                    else
                    begin
                        if (text_byte == CH_LF)
                        begin
                            mode_next = kwt_pkg::MODE_IDLE;
                        end
                        adv = 1'b1;
                    end
                end
                kwt_pkg::MODE_BLOCK, kwt_pkg::MODE_BSTAR:
                begin
                    if (text_byte == CH_NUL)
                    begin
                        b_vld = 1'b1;
                        res_b = make_res(kwt_pkg::KIND_END, kwt_pkg::NOT_KEYWORD, line_reg,
                                         col_reg, '0, kwt_pkg::ERR_NONE);
                        clr   = 1'b1;
                    end
                    else
                    begin
                        if (mode_eff == kwt_pkg::MODE_BSTAR && text_byte == CH_SLASH)
                        begin
                            mode_next = kwt_pkg::MODE_IDLE;
                        end
                        else if (text_byte == CH_STAR)
                        begin
                            mode_next = kwt_pkg::MODE_BSTAR;
                        end
                        else
                        begin
                            mode_next = kwt_pkg::MODE_BLOCK;
                        end
                        adv = 1'b1;
                    end
                end
                default:
                begin
                    if (kwt_pkg::is_space(text_byte))
                    begin
                        adv = 1'b1;
                    end
                    else if (kwt_pkg::is_alpha(text_byte) || text_byte == CH_UNDER)
                    begin
                        mode_next  = kwt_pkg::MODE_IDENT;
                        start_next = col_reg;
                        cand_next  = kwt_pkg::kw_match(8'hFF, '0, text_byte);
                        count_next = kwt_pkg::pos_t'(1);
                        adv        = 1'b1;
                    end
                    else
                    begin
                        case (text_byte)
                            CH_NUL:
                            begin
                                b_vld = 1'b1;
                                res_b = make_res(kwt_pkg::KIND_END, kwt_pkg::NOT_KEYWORD,
                                                 line_reg, col_reg, '0, kwt_pkg::ERR_NONE);
                                clr   = 1'b1;
                            end
                            CH_COMMA, CH_COLON, CH_SEMI, CH_LBRACE, CH_RBRACE:
                            begin
                                b_vld = 1'b1;
                                res_b = make_res(kwt_pkg::KIND_COMMA, kwt_pkg::NOT_KEYWORD,
                                                 line_reg, col_reg, kwt_pkg::pos_t'(1),
                                                 kwt_pkg::ERR_NONE);
                                case (text_byte)
                                    CH_COLON:  res_b.kind = kwt_pkg::KIND_COLON;
                                    CH_SEMI:   res_b.kind = kwt_pkg::KIND_SEMI;
                                    CH_LBRACE: res_b.kind = kwt_pkg::KIND_LBRACE;
                                    CH_RBRACE: res_b.kind = kwt_pkg::KIND_RBRACE;
                                    default:   res_b.kind = kwt_pkg::KIND_COMMA;
                                endcase
                                adv = 1'b1;
                            end
                            CH_QUOTE:
                            begin
                                mode_next  = kwt_pkg::MODE_STRING;
                                start_next = col_reg;
                                count_next = kwt_pkg::pos_t'(1);
                                adv        = 1'b1;
                            end
                            CH_SLASH:
                            begin
                                mode_next  = kwt_pkg::MODE_SLASH;
                                start_next = col_reg;
                                adv        = 1'b1;
                            end
                            default:
                            begin
                                b_vld = 1'b1;
                                res_b = make_res(kwt_pkg::KIND_END, kwt_pkg::NOT_KEYWORD,
                                                 line_reg, col_reg - 1'b1, '0,
                                                 kwt_pkg::ERR_UNDEFINED);
                                clr   = 1'b1;
                            end
                        endcase
                    end
                end
            endcase
        end

        if (adv)
        begin
            if (text_byte == CH_LF)
            begin
                line_next = kwt_pkg::sat_inc(line_reg);
                col_next  = kwt_pkg::pos_t'(1);
            end
            else
            begin
                col_next = kwt_pkg::sat_inc(col_reg);
            end
        end

        if (clr)
        begin
            mode_next  = kwt_pkg::MODE_IDLE;
            line_next  = kwt_pkg::pos_t'(1);
            col_next   = kwt_pkg::pos_t'(1);
            start_next = '0;
            count_next = '0;
            cand_next  = 8'hFF;
        end

        if (b_vld)
        begin
            res_b.last = 1'b1;
        end
        else
        begin
            res_a.last = 1'b1;
        end

        push.cnt    = step ? (2'(a_vld) + 2'(b_vld)) : 2'd0;
        push.first  = a_vld ? res_a : res_b;
        push.second = res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= kwt_pkg::MODE_IDLE;
            line_reg  <= kwt_pkg::pos_t'(1);
            col_reg   <= kwt_pkg::pos_t'(1);
            start_reg <= '0;
            count_reg <= '0;
            cand_reg  <= 8'hFF;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            start_reg <= start_next;
            count_reg <= count_next;
            cand_reg  <= cand_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step && b_vld && res_b.kind == kwt_pkg::KIND_END
        |=> mode_reg == kwt_pkg::MODE_IDLE && line_reg == kwt_pkg::pos_t'(1))
        else $error("end or error did not restart the scanner");

    a_ident_closes: assert property (@(posedge clk) disable iff (!rst_n)
        step && mode_reg == kwt_pkg::MODE_IDENT && !kwt_pkg::is_ident(text_byte)
        |=> mode_reg != kwt_pkg::MODE_IDENT)
        else $error("identifier did not close on a non-identifier byte");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0 && col_reg != '0)
        else $error("line or column count reached zero");
`endif

endmodule

`default_nettype wire

// ===== rtl/kwt_result_fifo.sv =====
`default_nettype none

module kwt_result_fifo (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire kwt_pkg::push_t                 push,
    input  wire logic                           pop_ready,
    output kwt_pkg::result_t                    head,
    output logic                                head_valid,
    output logic                                room
);

    kwt_pkg::result_t mem [kwt_pkg::FIFO_DEPTH];

    logic [kwt_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [kwt_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [kwt_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic                           pop;

    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign pop        = head_valid && pop_ready;
    // two free entries cover the largest request from one byte
    assign room       = (count_reg <= kwt_pkg::FIFO_CNT_W'(kwt_pkg::FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + kwt_pkg::FIFO_PTR_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + kwt_pkg::FIFO_PTR_W'(pop);
        count_next  = count_reg + kwt_pkg::FIFO_CNT_W'(push.cnt)
                      - kwt_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.cnt == 2'd2)
        begin
            mem[wr_ptr_reg + 1'b1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd0 |-> room)
        else $error("result queue written without room");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= kwt_pkg::FIFO_CNT_W'(kwt_pkg::FIFO_DEPTH))
        else $error("result queue count out of range");
`endif

endmodule

`default_nettype wire
